FILE: design/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// Types and constants shared by the sorted run former modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

  localparam logic [7:0] SENTINEL = 8'd124;

  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic CFG_RUN_LENGTH = 1'b0;
  localparam logic CFG_WAY_COUNT  = 1'b1;

  localparam int RUN_W = 6;
  localparam int WAY_W = 5;
  localparam int DEST_W = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic [7:0]        char_out;
    logic [DEST_W-1:0] dest_file;
    logic              last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic              ins;
    logic              shift;
    logic              load_letter;
    logic              load_sent;
    logic              last;
    logic [DEST_W-1:0] dest;
    logic [RUN_W-1:0]  run_eff;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fill_zero;
    logic fill_one;
    logic run_full;
    logic out_free;
  } sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

endpackage

`default_nettype wire

FILE: design/srf_datapath.sv
// ----------------------------------------------------------------------------
// srf_datapath
// Insertion-sort cell row, fill counter and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_datapath #(
  parameter int MAX_RUN = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire srf_pkg::cmd_t    cmd,
  input  wire [7:0]             char_in,
  input  wire                   out_ready,
  output srf_pkg::sts_t         sts,
  output logic                  out_valid,
  output srf_pkg::out_t         out_data
);

  localparam int FW = $clog2(MAX_RUN + 1);

  logic [7:0]    cell_r   [MAX_RUN];
  logic [7:0]    cell_nxt [MAX_RUN];
  logic [MAX_RUN-1:0] gt;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [FW:0]   fill_inc;
  logic          out_valid_r;
  srf_pkg::out_t out_data_r;

  // An entry at or beyond the fill count behaves as larger than any letter,
  // so the row stays sorted with the new letter dropped into place.
  always_comb begin
    for (int i = 0; i < MAX_RUN; i++) begin
      gt[i] = (FW'(i) >= fill_r) || (cell_r[i] > char_in);
    end
    for (int i = 0; i < MAX_RUN; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.ins) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end else if (gt[i]) begin
          cell_nxt[i] = char_in;
        end
      end else if (cmd.shift && i < MAX_RUN - 1) begin
        cell_nxt[i] = cell_r[(i < MAX_RUN - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    fill_inc = (fill_r == FW'(MAX_RUN)) ? {1'b0, fill_r} : {1'b0, fill_r} + 1'b1;
    fill_nxt = fill_r;
    if (cmd.ins) begin
      fill_nxt = fill_inc[FW-1:0];
    end else if (cmd.shift) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RUN; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.load_letter || cmd.load_sent) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.load_letter) begin
      out_data_r <= '{char_out: cell_r[0], dest_file: cmd.dest, last: cmd.last};
    end else if (cmd.load_sent) begin
      out_data_r <= '{char_out: srf_pkg::SENTINEL, dest_file: cmd.dest, last: 1'b1};
    end
  end

  always_comb begin
    sts.fill_zero = (fill_r == '0);
    sts.fill_one  = (fill_r == FW'(1));
    sts.run_full  = (7'(fill_inc) >= 7'(cmd.run_eff));
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: design/srf_ctrl.sv
// ----------------------------------------------------------------------------
// srf_ctrl
// Run controller: configuration registers, destination counter and the
// collect / drain / sentinel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_ctrl #(
  parameter int MAX_RUN  = 32,
  parameter int MAX_WAYS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire srf_pkg::in_t     in_data,
  input  wire                   cfg_we,
  input  wire                   cfg_idx,
  input  wire [5:0]             cfg_wdata,
  input  wire srf_pkg::sts_t    sts,
  output srf_pkg::cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SENT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       flush_r, flush_nxt;
  logic [srf_pkg::DEST_W-1:0] dest_r, dest_nxt;
  logic [srf_pkg::RUN_W-1:0]  run_len_r;
  logic [srf_pkg::WAY_W-1:0]  way_cnt_r;
  logic [srf_pkg::RUN_W-1:0]  run_eff;
  logic [srf_pkg::WAY_W-1:0]  way_eff;
  logic [srf_pkg::WAY_W-1:0]  dest_inc;

  always_comb begin
    if (run_len_r == '0) begin
      run_eff = srf_pkg::RUN_W'(1);
    end else if (7'(run_len_r) > 7'(MAX_RUN)) begin
      run_eff = srf_pkg::RUN_W'(MAX_RUN);
    end else begin
      run_eff = run_len_r;
    end
    if (way_cnt_r == '0) begin
      way_eff = srf_pkg::WAY_W'(1);
    end else if (way_cnt_r > srf_pkg::WAY_W'(MAX_WAYS)) begin
      way_eff = srf_pkg::WAY_W'(MAX_WAYS);
    end else begin
      way_eff = way_cnt_r;
    end
    dest_inc = {1'b0, dest_r} + 1'b1;
  end

  always_comb begin
    state_nxt   = state_r;
    flush_nxt   = flush_r;
    dest_nxt    = dest_r;
    in_ready    = (state_r == ST_IDLE);
    cmd         = '0;
    cmd.dest    = dest_r;
    cmd.run_eff = run_eff;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == srf_pkg::REQ_FLUSH) begin
            if (sts.fill_zero) begin
              dest_nxt = '0;
            end else begin
              flush_nxt = 1'b1;
              state_nxt = ST_DRAIN;
            end
          end else if (srf_pkg::is_letter(in_data.char_in)) begin
            cmd.ins = 1'b1;
            if (sts.run_full) begin
              flush_nxt = 1'b0;
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.load_letter = 1'b1;
          cmd.shift       = 1'b1;
          cmd.last        = flush_r && sts.fill_one;
          if (sts.fill_one) begin
            if (flush_r) begin
              dest_nxt  = '0;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_SENT;
            end
          end
        end
      end
      ST_SENT: begin
        if (sts.out_free) begin
          cmd.load_sent = 1'b1;
          state_nxt     = ST_IDLE;
          dest_nxt      = (dest_inc >= way_eff) ? '0 : dest_inc[srf_pkg::DEST_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      flush_r   <= 1'b0;
      dest_r    <= '0;
      run_len_r <= srf_pkg::RUN_W'(32);
      way_cnt_r <= srf_pkg::WAY_W'(2);
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      dest_r  <= dest_nxt;
      if (cfg_we) begin
        if (cfg_idx == srf_pkg::CFG_RUN_LENGTH) begin
          run_len_r <= cfg_wdata;
        end else begin
          way_cnt_r <= cfg_wdata[srf_pkg::WAY_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/sorted_run_former_core.sv
// The letter that completes a run moves the controller to its drain state,
// and the first word is loaded into the output register once it is free;
// each letter is sorted in as it arrives. Letters are taken one per cycle
// while collecting; then the words of a run and its sentinel drain one per
// cycle while out_ready is high, input held off; the row drain sets the pace.
// Synchronous reset: empty row, destination 0, run_length 32, way_count 2.
// ----------------------------------------------------------------------------
// sorted_run_former_core
// Collects letters into sorted runs and emits them to round-robin files.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_run_former_core #(
  parameter int MAX_RUN  = 32,
  parameter int MAX_WAYS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire srf_pkg::in_t     in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output srf_pkg::out_t         out_data,
  input  wire                   cfg_we,
  input  wire                   cfg_idx,
  input  wire [5:0]             cfg_wdata
);

  srf_pkg::cmd_t cmd;
  srf_pkg::sts_t sts;

  srf_ctrl #(
    .MAX_RUN (MAX_RUN),
    .MAX_WAYS(MAX_WAYS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .sts      (sts),
    .cmd      (cmd)
  );

  srf_datapath #(
    .MAX_RUN(MAX_RUN)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .char_in  (in_data.char_in),
    .out_ready(out_ready),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/srf_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srf_run_checker
// Watches the input, result and register ports of the sorted run former,
// works out the sorted runs that each accepted word must produce and compares
// every accepted result word with the oldest one still due.
// ----------------------------------------------------------------------------

module srf_run_checker #(
  parameter int MAX_RUN  = 32,
  parameter int MAX_WAYS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire srf_pkg::in_t  in_data,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire srf_pkg::out_t out_data,
  input  wire                cfg_we,
  input  wire                cfg_idx,
  input  wire [5:0]          cfg_wdata,
  output int                 mismatches,
  output int                 words_due_n
);

  logic [5:0]    run_len_cfg;
  logic [4:0]    ways_cfg;
  logic [7:0]    held [MAX_RUN];
  int unsigned   held_n;
  logic [3:0]    dest_sel;
  srf_pkg::out_t sorted_words [$];

  // Queues the held letters in ascending byte order, tagged with the current
  // destination, optionally closed by the sentinel.
  task automatic append_run(input bit with_sentinel);
    logic [7:0]    order [MAX_RUN];
    logic [7:0]    v;
    srf_pkg::out_t w;
    int            n;
    int            a;
    int            b;
    n = held_n;
    for (a = 0; a < n; a++) order[a] = held[a];
    for (a = 1; a < n; a++) begin
      v = order[a];
      b = a;
      while (b > 0 && order[b-1] > v) begin
        order[b] = order[b-1];
        b--;
      end
      order[b] = v;
    end
    for (a = 0; a < n; a++) begin
      w.char_out  = order[a];
      w.dest_file = dest_sel;
      w.last      = !with_sentinel && (a == n - 1);
      sorted_words = {sorted_words, w};
    end
    if (with_sentinel) begin
      w.char_out  = srf_pkg::SENTINEL;
      w.dest_file = dest_sel;
      w.last      = 1'b1;
      sorted_words = {sorted_words, w};
    end
  endtask

  always @(posedge clk) begin
    srf_pkg::out_t want;
    int            lim;
    int            ways;
    int            nxt;
    if (!rst_n) begin
      run_len_cfg = 6'd32;
      ways_cfg    = 5'd2;
      held_n      = 0;
      dest_sel    = '0;
      mismatches  = 0;
      sorted_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_words.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word char=%0d dest=%0d last=%0b", $time,
                     out_data.char_out, out_data.dest_file, out_data.last);
          mismatches++;
        end else begin
          want = sorted_words.pop_front();
          if (out_data.char_out !== want.char_out ||
              out_data.dest_file !== want.dest_file ||
              out_data.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: word mismatch, expected char=%0d dest=%0d last=%0b",
                       $time, want.char_out, want.dest_file, want.last);
              $display("%0t:   got char=%0d dest=%0d last=%0b",
                       $time, out_data.char_out, out_data.dest_file, out_data.last);
            end
            mismatches++;
          end
        end
      end

      if (cfg_we) begin
        if (cfg_idx == srf_pkg::CFG_RUN_LENGTH) run_len_cfg = cfg_wdata;
        else ways_cfg = cfg_wdata[4:0];
      end

      if (in_valid && in_ready) begin
        if (in_data.req_type == srf_pkg::REQ_FLUSH) begin
          // End of stream: a partial run goes out without a sentinel and the
          // next stream starts again at file zero.
          if (held_n > 0) append_run(1'b0);
          held_n   = 0;
          dest_sel = '0;
        end else if ((in_data.char_in >= 8'd65 && in_data.char_in <= 8'd90) ||
                     (in_data.char_in >= 8'd97 && in_data.char_in <= 8'd122)) begin
          if (held_n < MAX_RUN) begin
            held[held_n] = in_data.char_in;
            held_n++;
          end
          lim = (run_len_cfg == 0) ? 1 : (run_len_cfg > MAX_RUN) ? MAX_RUN : run_len_cfg;
          // A run length lowered below the fill level takes effect here.
          if (held_n >= lim) begin
            append_run(1'b1);
            held_n = 0;
            ways = (ways_cfg == 0) ? 1 : (ways_cfg > MAX_WAYS) ? MAX_WAYS : ways_cfg;
            nxt  = dest_sel + 1;
            dest_sel = (nxt >= ways) ? 4'd0 : nxt[3:0];
          end
        end
      end
    end
    words_due_n = sorted_words.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives letters, noise bytes and flushes into the sorted run former under a
// range of run lengths and file counts, with random idling on both channels,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------

module tb_top;

  typedef enum {RX_ALWAYS, RX_COIN, RX_EVERY4, RX_LONG} rx_mode_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  srf_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  srf_pkg::out_t out_data;
  logic          cfg_we    = 1'b0;
  logic          cfg_idx   = 1'b0;
  logic [5:0]    cfg_wdata = '0;
  int            mismatches;
  int            words_due_n;

  int            burst_left = 0;
  rx_mode_t      rx_mode    = RX_ALWAYS;
  int            mode_left  = 0;
  int            stall_left = 0;
  int            tick       = 0;

  always #5 clk = ~clk;

  sorted_run_former_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  srf_run_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .words_due_n (words_due_n)
  );

  // The receiver changes its stall pattern at random intervals.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end
    mode_left--;
    tick++;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_EVERY4: out_ready <= (tick % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 16);
        end
      end
    endcase
  end

  // Sends one word; bursts of random length are separated by random gaps.
  task automatic send_word(input logic req, input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_data.req_type <= req;
    in_data.char_in  <= c;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  task automatic set_config(input logic [5:0] run_len, input logic [5:0] ways);
    cfg_we    <= 1'b1;
    cfg_idx   <= srf_pkg::CFG_RUN_LENGTH;
    cfg_wdata <= run_len;
    @(posedge clk);
    cfg_idx   <= srf_pkg::CFG_WAY_COUNT;
    cfg_wdata <= ways;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stops sending and waits until every predicted word has come out, then
  // lets the block settle after words that produce nothing.
  task automatic drain();
    int guard;
    in_valid   <= 1'b0;
    burst_left = 0;
    guard      = 0;
    @(posedge clk);
    while (words_due_n != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] probes [10];
    int         n;
    int         k;
    int         sent_n;
    logic [5:0] rl;
    logic [5:0] wc;
    probes = '{8'd122, 8'd65, 8'd64, 8'd97, 8'd91, 8'd90, 8'd96, 8'd123, 8'd0, 8'd255};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a flush on an empty buffer, letters mixed with the bytes
    // next to the letter ranges, then a flush of the partial run.
    send_word(srf_pkg::REQ_FLUSH, 8'h00);
    foreach (probes[i]) send_word(srf_pkg::REQ_CHAR, probes[i]);
    send_word(srf_pkg::REQ_FLUSH, 8'hFF);
    drain();

    // Zero run length and zero file count both behave as one.
    set_config(6'd0, 6'd0);
    send_word(srf_pkg::REQ_CHAR, 8'd113);
    send_word(srf_pkg::REQ_CHAR, 8'd66);
    drain();

    // Single letter runs over sixteen files leave the destination at five.
    set_config(6'd1, 6'd16);
    repeat (5) send_word(srf_pkg::REQ_CHAR, rand_letter());
    drain();

    // Destination now lies above the file count, and the run length is
    // lowered under the fill level before the next letter arrives.
    set_config(6'd63, 6'd3);
    repeat (3) send_word(srf_pkg::REQ_CHAR, rand_letter());
    drain();
    set_config(6'd2, 6'd3);
    send_word(srf_pkg::REQ_CHAR, rand_letter());
    send_word(srf_pkg::REQ_FLUSH, rand_letter());
    drain();

    sent_n = 0;
    while (sent_n < 190) begin
      case ($urandom_range(0, 9))
        0:       rl = 6'd32;
        1:       rl = 6'($urandom_range(33, 63));
        2:       rl = 6'd0;
        3:       rl = 6'd1;
        default: rl = 6'($urandom_range(2, 8));
      endcase
      wc = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 5));
      set_config(rl, wc);
      n = $urandom_range(15, 40);
      repeat (n) begin
        k = $urandom_range(0, 99);
        if (k < 4) begin
          send_word(srf_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
        end else if (k < 18) begin
          send_word(srf_pkg::REQ_CHAR, 8'($urandom_range(0, 255)));
        end else begin
          send_word(srf_pkg::REQ_CHAR, rand_letter());
        end
        sent_n++;
      end
      if ($urandom_range(0, 2) == 0) begin
        send_word(srf_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
        sent_n++;
      end
      drain();
    end

    if (mismatches == 0 && words_due_n == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
